// File: sv/bbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_pkg
// shared types and constants of the bounding box normalizer
// ----------------------------------------------------------------------------
package bbn_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLOSE,
        S_FINDK,
        S_DIV,
        S_SUM,
        S_XL,
        S_XH,
        S_XS,
        S_YL,
        S_YH,
        S_YS,
        S_EMIT
    } t_state;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_ZERO_EXT  = 2'd1;
    localparam t_status STATUS_NO_BOUNDS = 2'd2;

    localparam logic        KIND_BOUND     = 1'b0;
    localparam logic        KIND_TRANSFORM = 1'b1;
    localparam logic [31:0] ELEV_ONE       = 32'h0001_0000;
    localparam logic        NEG_DEPTH_RST  = 1'b1;

endpackage : bbn_pkg
`default_nettype wire

// File: sv/bbn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_front
// input side: holds the depth sign setting and packs each point for the queue
// ----------------------------------------------------------------------------
module bbn_front #(
    parameter int W = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_wdata,
    input  wire logic                 i_kind,
    input  wire logic [W-1:0]         i_coord_x,
    input  wire logic [W-1:0]         i_coord_y,
    input  wire logic [W-1:0]         i_coord_z,
    input  wire logic                 i_last_point,
    output logic      [3*W+1:0]       o_entry
);
    import bbn_pkg::*;

    logic r_negate;
    logic [W-1:0] w_z;
    logic [W-1:0] w_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate <= NEG_DEPTH_RST;
        end else if (i_cfg_we) begin
            r_negate <= i_cfg_wdata;
        end
    end

    assign w_min = {1'b1, {(W-1){1'b0}}};

    // negating the most negative depth saturates to the largest positive value
    always_comb begin
        if (!r_negate) begin
            w_z = i_coord_z;
        end else if (i_coord_z == w_min) begin
            w_z = ~w_min;
        end else begin
            w_z = W'(-i_coord_z);
        end
    end

    assign o_entry = {i_kind, i_last_point, i_coord_x, i_coord_y, w_z};

endmodule : bbn_front
`default_nettype wire

// File: sv/bbn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_queue
// two-entry queue between the input side and the engine
// ----------------------------------------------------------------------------
module bbn_queue #(
    parameter int DW = 98
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_nonempty,
    output logic      [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule : bbn_queue
`default_nettype wire

// File: sv/bbn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbn_back
// engine: bounds tracking, reciprocal by restoring division, scaling
// ----------------------------------------------------------------------------
module bbn_back #(
    parameter int W = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_nonempty,
    input  wire logic [3*W+1:0]  i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic                 o_result_kind,
    output logic      [31:0]     o_norm_x,
    output logic      [31:0]     o_norm_y,
    output logic      [31:0]     o_out_depth,
    output logic      [31:0]     o_elev_min,
    output logic      [31:0]     o_elev_max,
    output logic      [1:0]      o_status
);
    import bbn_pkg::*;

    localparam int KW = $clog2(W + 1);
    localparam int PW = W + 33;
    localparam int CW = $clog2(W + 32);

    function automatic logic [31:0] f_out32(input logic signed [W-1:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    t_state r_state, n_state;

    logic        w_kind, w_last;
    logic signed [W-1:0] w_x, w_y, w_z;

    logic signed [W-1:0] r_low_x, r_high_x, r_low_y, r_high_y, r_low_z, r_high_z;
    logic signed [W-1:0] r_center_x, r_center_y;
    logic [31:0]         r_inv;
    logic [KW-1:0]       r_k;
    logic                r_bounds_valid, r_pass_open;

    logic [W-1:0]  r_e, r_tmp;
    logic [W:0]    r_rem;
    logic [31:0]   r_q;
    logic [CW-1:0] r_cnt;

    logic [W:0]    r_mag_x, r_mag_y;
    logic          r_neg_x, r_neg_y;
    logic [PW-1:0] r_p;
    logic [31:0]   r_mul_a;

    logic [31:0]   r_o_nx, r_o_ny, r_o_depth, r_o_emin, r_o_emax;
    logic          r_o_kind;
    t_status       r_o_status;

    logic [63:0]   w_prod;
    logic [63:0]   w_mx64, w_my64;
    logic          w_immediate, w_div_last;
    logic signed [W:0] w_dx, w_dy, w_sx, w_sy;
    logic [W:0]    w_ex, w_ey;
    logic [W+1:0]  w_rem2;
    logic          w_ge;
    logic [PW-1:0] w_q;
    logic          w_neg;
    logic [31:0]   w_sat;
    logic [31:0]   w_inv_final;

    assign {w_kind, w_last, w_x, w_y, w_z} = i_entry;

    assign w_dx = {w_x[W-1], w_x} - {r_center_x[W-1], r_center_x};
    assign w_dy = {w_y[W-1], w_y} - {r_center_y[W-1], r_center_y};
    assign w_sx = {r_low_x[W-1], r_low_x} + {r_high_x[W-1], r_high_x};
    assign w_sy = {r_low_y[W-1], r_low_y} + {r_high_y[W-1], r_high_y};
    assign w_ex = {r_high_x[W-1], r_high_x} - {r_low_x[W-1], r_low_x};
    assign w_ey = {r_high_y[W-1], r_high_y} - {r_low_y[W-1], r_low_y};

    // transform point that needs no scaling
    assign w_immediate = !r_bounds_valid || (r_inv == 32'd0);

    assign w_rem2     = {r_rem, 1'b1};
    assign w_ge       = (w_rem2 >= (W+2)'(r_e));
    assign w_div_last = (r_cnt == CW'(30 + int'(r_k)));
    assign w_inv_final = (r_k == '0) ? 32'd0 : r_q;

    assign w_mx64 = 64'(r_mag_x);
    assign w_my64 = 64'(r_mag_y);
    assign w_prod = 64'(r_mul_a) * 64'(r_inv);

    // truncate toward zero then saturate to q1.30 range
    // the x product is complete in S_YL, the y product in S_YS
    assign w_q   = r_p >> r_k;
    assign w_neg = (r_state == S_YL) ? r_neg_x : r_neg_y;
    always_comb begin
        if (w_neg) begin
            w_sat = (w_q > PW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-w_q);
        end else begin
            w_sat = (w_q > PW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : w_q[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_nonempty) begin
                    if (w_kind == KIND_BOUND) begin
                        n_state = w_last ? S_CLOSE : S_IDLE;
                    end else begin
                        n_state = w_immediate ? S_EMIT : S_XL;
                    end
                end
            end
            S_CLOSE: n_state = S_FINDK;
            S_FINDK: begin
                if (r_tmp == '0) begin
                    n_state = (r_k == '0) ? S_SUM : S_DIV;
                end
            end
            S_DIV:  n_state = w_div_last ? S_SUM : S_DIV;
            S_SUM:  n_state = S_EMIT;
            S_XL:   n_state = S_XH;
            S_XH:   n_state = S_XS;
            S_XS:   n_state = S_YL;
            S_YL:   n_state = S_YH;
            S_YH:   n_state = S_YS;
            S_YS:   n_state = S_EMIT;
            S_EMIT: n_state = i_ready ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = (r_state == S_IDLE) && i_nonempty;
        o_valid = (r_state == S_EMIT);
    end

    assign o_result_kind = r_o_kind;
    assign o_norm_x      = r_o_nx;
    assign o_norm_y      = r_o_ny;
    assign o_out_depth   = r_o_depth;
    assign o_elev_min    = r_o_emin;
    assign o_elev_max    = r_o_emax;
    assign o_status      = r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // bounds state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_x        <= '0;
            r_high_x       <= '0;
            r_low_y        <= '0;
            r_high_y       <= '0;
            r_low_z        <= '0;
            r_high_z       <= '0;
            r_center_x     <= '0;
            r_center_y     <= '0;
            r_inv          <= '0;
            r_k            <= '0;
            r_bounds_valid <= 1'b0;
            r_pass_open    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_nonempty && (w_kind == KIND_BOUND)) begin
                        if (!r_pass_open) begin
                            r_low_x        <= w_x;
                            r_high_x       <= w_x;
                            r_low_y        <= w_y;
                            r_high_y       <= w_y;
                            r_low_z        <= w_z;
                            r_high_z       <= w_z;
                            r_pass_open    <= 1'b1;
                            r_bounds_valid <= 1'b0;
                        end else begin
                            if (w_x < r_low_x)  r_low_x  <= w_x;
                            if (w_x > r_high_x) r_high_x <= w_x;
                            if (w_y < r_low_y)  r_low_y  <= w_y;
                            if (w_y > r_high_y) r_high_y <= w_y;
                            if (w_z < r_low_z)  r_low_z  <= w_z;
                            if (w_z > r_high_z) r_high_z <= w_z;
                        end
                    end
                end
                S_CLOSE: begin
                    r_center_x <= W'(w_sx >>> 1);
                    r_center_y <= W'(w_sy >>> 1);
                    r_k        <= '0;
                end
                S_FINDK: begin
                    if (r_tmp != '0) begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_SUM: begin
                    r_inv          <= w_inv_final;
                    r_bounds_valid <= 1'b1;
                    r_pass_open    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mag_x <= w_dx[W] ? (W+1)'(-w_dx) : w_dx;
                r_mag_y <= w_dy[W] ? (W+1)'(-w_dy) : w_dy;
                r_neg_x <= w_dx[W];
                r_neg_y <= w_dy[W];
                r_o_kind  <= KIND_TRANSFORM;
                r_o_nx    <= '0;
                r_o_ny    <= '0;
                r_o_depth <= f_out32(w_z);
                if (!r_bounds_valid) begin
                    r_o_emin   <= '0;
                    r_o_emax   <= ELEV_ONE;
                    r_o_status <= STATUS_NO_BOUNDS;
                end else begin
                    r_o_emin   <= f_out32(r_low_z);
                    r_o_emax   <= f_out32(r_high_z);
                    r_o_status <= (r_inv == 32'd0) ? STATUS_ZERO_EXT : STATUS_OK;
                end
            end
            S_CLOSE: begin
                r_e   <= (w_ex > w_ey) ? w_ex[W-1:0] : w_ey[W-1:0];
                r_tmp <= (w_ex > w_ey) ? w_ex[W-1:0] : w_ey[W-1:0];
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_FINDK: begin
                r_tmp <= r_tmp >> 1;
            end
            S_DIV: begin
                r_rem <= w_ge ? (W+1)'(w_rem2 - (W+2)'(r_e)) : (W+1)'(w_rem2);
                r_q   <= {r_q[30:0], w_ge};
                r_cnt <= r_cnt + CW'(1);
            end
            S_SUM: begin
                r_o_kind   <= KIND_BOUND;
                r_o_nx     <= '0;
                r_o_ny     <= '0;
                r_o_depth  <= '0;
                r_o_emin   <= f_out32(r_low_z);
                r_o_emax   <= f_out32(r_high_z);
                r_o_status <= (w_inv_final == 32'd0) ? STATUS_ZERO_EXT : STATUS_OK;
            end
            S_XL: begin
                r_mul_a <= w_mx64[31:0];
            end
            S_XH: begin
                r_p     <= PW'(w_prod);
                r_mul_a <= w_mx64[63:32];
            end
            S_XS: begin
                r_p     <= r_p + PW'({w_prod, 32'd0});
                r_mul_a <= w_my64[31:0];
            end
            S_YL: begin
                r_o_nx  <= w_sat;
                r_mul_a <= w_my64[63:32];
                r_p     <= PW'(w_prod);
            end
            S_YH: begin
                r_p <= r_p + PW'({w_prod, 32'd0});
            end
            S_YS: begin
                r_o_ny <= w_sat;
            end
            default: begin
            end
        endcase
    end

endmodule : bbn_back
`default_nettype wire

// File: sv/bounding_box_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_box_normalizer_unit
// maps mesh points into the unit square from a bounding pass
// ----------------------------------------------------------------------------
// A bounding point that is not the last only updates the bounds. The last
// bounding point also finds the bit length k of the larger extent, one bit a
// cycle, then runs a restoring division that yields 31+k quotient bits for
// the reciprocal. A transform point that is scaled passes through one shared
// 32x32 multiplier (two partial products per axis plus a shift and saturate
// step); unscaled ones go straight to the output. A two-entry queue lets the
// input side keep accepting while the engine works or waits.
module bounding_box_normalizer_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_kind,
    input  wire logic [COORD_WIDTH-1:0] i_coord_x,
    input  wire logic [COORD_WIDTH-1:0] i_coord_y,
    input  wire logic [COORD_WIDTH-1:0] i_coord_z,
    input  wire logic                   i_last_point,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_result_kind,
    output logic [31:0]                 o_norm_x,
    output logic [31:0]                 o_norm_y,
    output logic [31:0]                 o_out_depth,
    output logic [31:0]                 o_elev_min,
    output logic [31:0]                 o_elev_max,
    output logic [1:0]                  o_status
);
    localparam int DW = 3 * COORD_WIDTH + 2;

    logic [DW-1:0] w_entry_in, w_entry_out;
    logic          w_full, w_nonempty, w_pop, w_push;

    assign o_ready = !w_full;
    assign w_push  = i_valid && !w_full;

    bbn_front #(.W(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (i_kind),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_last_point(i_last_point),
        .o_entry     (w_entry_in)
    );

    bbn_queue #(.DW(DW)) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_data    (w_entry_in),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_nonempty(w_nonempty),
        .o_data    (w_entry_out)
    );

    bbn_back #(.W(COORD_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (w_nonempty),
        .i_entry      (w_entry_out),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_kind(o_result_kind),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_out_depth  (o_out_depth),
        .o_elev_min   (o_elev_min),
        .o_elev_max   (o_elev_max),
        .o_status     (o_status)
    );

endmodule : bounding_box_normalizer_unit
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams bounding and transform passes of mesh points through the bounding
// box normalizer and compares every result, field by field, with a predicted
// result. Depth negation is switched between phases, and the sender and the
// receiver idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import bbn_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic        last_pt;
    logic        out_valid;
    logic        out_ready;
    logic        r_kind;
    logic [31:0] r_nx;
    logic [31:0] r_ny;
    logic [31:0] r_depth;
    logic [31:0] r_emin;
    logic [31:0] r_emax;
    logic [1:0]  r_status;

    typedef struct packed {
        logic        kind;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] depth;
        logic [31:0] emin;
        logic [31:0] emax;
        logic [1:0]  status;
    } t_norm_result;

    typedef struct packed {
        logic        kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        has_fixed;
        t_norm_result fixed;
    } t_point_row;

    bounding_box_normalizer_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready), .i_kind(kind), .i_coord_x(cx),
        .i_coord_y(cy), .i_coord_z(cz), .i_last_point(last_pt),
        .o_valid(out_valid), .i_ready(out_ready), .o_result_kind(r_kind),
        .o_norm_x(r_nx), .o_norm_y(r_ny), .o_out_depth(r_depth),
        .o_elev_min(r_emin), .o_elev_max(r_emax), .o_status(r_status)
    );

    // predictor state
    logic signed [63:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z, mid_x, mid_y;
    logic [31:0]        recip;
    int unsigned        recip_shift;
    logic               have_bounds, pass_busy, neg_depth;

    t_norm_result pending_results[$];
    int  errors;
    int  results_seen;
    int  summaries_seen;
    int  send_idle_pct;
    int  recv_idle_pct;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #40000000;
        $display("bounding_box_normalizer_unit verification failed");
        $finish;
    end

    function automatic logic signed [63:0] sign_ext(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [63:0] depth_value(logic [31:0] raw);
        logic signed [63:0] z;
        z = sign_ext(raw);
        if (neg_depth) begin
            z = -z;
            if (z > 64'sd2147483647) z = 64'sd2147483647;
        end
        return z;
    endfunction

    function automatic logic signed [63:0] midpoint(logic signed [63:0] a,
                                                    logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s >= 0) return s / 2;
        return -((-s + 1) / 2);
    endfunction

    function automatic logic signed [63:0] scale_offset(logic signed [63:0] d);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic         neg;
        neg = d < 0;
        mag = neg ? -d : d;
        if (recip_shift == 0) return 0;
        prod = {64'd0, mag} * {96'd0, recip};
        q = prod >> recip_shift;
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -$signed({1'b0, q[62:0]});
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return $signed({1'b0, q[62:0]});
    endfunction

    // returns 1 when the point produces a result
    function automatic logic predict_point(t_point_row p, output t_norm_result r);
        logic signed [63:0] x, y, z;
        logic [63:0] ex, ey, e, rem, qt;
        int unsigned k;
        x = sign_ext(p.x);
        y = sign_ext(p.y);
        z = depth_value(p.z);
        r = '0;
        r.kind = p.kind;
        r.emax = ELEV_ONE;
        if (p.kind == KIND_BOUND) begin
            if (!pass_busy) begin
                lo_x = x; hi_x = x; lo_y = y; hi_y = y; lo_z = z; hi_z = z;
                pass_busy = 1'b1;
                have_bounds = 1'b0;
            end else begin
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
                if (z < lo_z) lo_z = z;
                if (z > hi_z) hi_z = z;
            end
            if (!p.last) return 1'b0;
            ex = hi_x - lo_x;
            ey = hi_y - lo_y;
            e = ex > ey ? ex : ey;
            mid_x = midpoint(lo_x, hi_x);
            mid_y = midpoint(lo_y, hi_y);
            if (e == 0) begin
                recip = '0;
                recip_shift = 0;
            end else begin
                k = 0;
                while (k < 64 && (e >> k) != 0) k++;
                rem = 0;
                qt = 0;
                for (int i = 0; i < 31 + k; i++) begin
                    rem = (rem << 1) | 64'd1;
                    qt = qt << 1;
                    if (rem >= e) begin
                        rem = rem - e;
                        qt[0] = 1'b1;
                    end
                end
                recip = qt[31:0];
                recip_shift = k;
            end
            have_bounds = 1'b1;
            pass_busy = 1'b0;
            r.emin = lo_z[31:0];
            r.emax = hi_z[31:0];
            r.status = (recip == 0) ? STATUS_ZERO_EXT : STATUS_OK;
        end else begin
            r.depth = z[31:0];
            if (!have_bounds) begin
                r.status = STATUS_NO_BOUNDS;
            end else begin
                r.emin = lo_z[31:0];
                r.emax = hi_z[31:0];
                if (recip == 0) begin
                    r.status = STATUS_ZERO_EXT;
                end else begin
                    r.status = STATUS_OK;
                    r.nx = scale_offset(x - mid_x);
                    r.ny = scale_offset(y - mid_y);
                end
            end
        end
        return 1'b1;
    endfunction

    // valid stays high between back to back transfers
    task automatic send_point(t_point_row p);
        t_norm_result r;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (predict_point(p, r)) begin
            if (p.has_fixed && r != p.fixed) begin
                $display("%0t table row differs: table %h predictor %h", $time,
                         p.fixed, r);
                errors++;
            end
            pending_results = {pending_results, r};
        end
        in_valid <= 1'b1;
        kind <= p.kind;
        cx <= p.x;
        cy <= p.y;
        cz <= p.z;
        last_pt <= p.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (120) @(posedge clk);
    endtask

    task automatic write_negate(logic v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        neg_depth = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_point_row mk(logic k, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic l);
        t_point_row p;
        p = '0;
        p.kind = k; p.x = x; p.y = y; p.z = z; p.last = l;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(2000, 0) - 1000;
            2: return {$urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $urandom_range(32'h0010_0000, 0) - 32'h0008_0000;
        endcase
    endfunction

    // receiver side
    always @(posedge clk) begin
        t_norm_result got;
        t_norm_result want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = '{r_kind, r_nx, r_ny, r_depth, r_emin, r_emax, r_status};
                results_seen++;
                if (r_kind == KIND_BOUND) summaries_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind != want.kind)
                        $display("%0t kind expected %h actual %h", $time, want.kind,
                                 got.kind);
                    if (got.nx != want.nx)
                        $display("%0t norm_x expected %h actual %h", $time, want.nx,
                                 got.nx);
                    if (got.ny != want.ny)
                        $display("%0t norm_y expected %h actual %h", $time, want.ny,
                                 got.ny);
                    if (got.depth != want.depth)
                        $display("%0t out_depth expected %h actual %h", $time,
                                 want.depth, got.depth);
                    if (got.emin != want.emin)
                        $display("%0t elev_min expected %h actual %h", $time,
                                 want.emin, got.emin);
                    if (got.emax != want.emax)
                        $display("%0t elev_max expected %h actual %h", $time,
                                 want.emax, got.emax);
                    if (got.status != want.status)
                        $display("%0t status expected %h actual %h", $time,
                                 want.status, got.status);
                    if (got != want) errors++;
                end
            end
            out_ready <= (recv_idle_pct == 0) ? 1'b1
                       : ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    initial begin
        t_point_row dir_rows[$];
        t_point_row p;
        t_norm_result fx;
        int pass_len, mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        cx = '0;
        cy = '0;
        cz = '0;
        last_pt = 1'b0;
        out_ready = 1'b1;
        errors = 0;
        results_seen = 0;
        summaries_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
        mid_x = 0; mid_y = 0; recip = 0; recip_shift = 0;
        have_bounds = 1'b0; pass_busy = 1'b0; neg_depth = NEG_DEPTH_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // transform before any bounds exist
        p = mk(KIND_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
        fx = '{KIND_TRANSFORM, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0, ELEV_ONE,
               STATUS_NO_BOUNDS};
        p.has_fixed = 1'b1; p.fixed = fx;
        dir_rows = {dir_rows, p};
        // single point pass: zero extent, most negative depth saturates
        p = mk(KIND_BOUND, 32'h0000_1000, 32'h0000_2000, 32'h8000_0000, 1'b1);
        fx = '{KIND_BOUND, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               STATUS_ZERO_EXT};
        p.has_fixed = 1'b1; p.fixed = fx;
        dir_rows = {dir_rows, p};
        p = mk(KIND_TRANSFORM, 32'h1234_5678, 32'd5, 32'd0, 1'b0);
        fx = '{KIND_TRANSFORM, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               STATUS_ZERO_EXT};
        p.has_fixed = 1'b1; p.fixed = fx;
        dir_rows = {dir_rows, p};
        // full range extents, y wider than x
        dir_rows = {dir_rows,
                    mk(KIND_BOUND, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0)};
        dir_rows = {dir_rows,
                    mk(KIND_BOUND, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0)};
        dir_rows = {dir_rows,
                    mk(KIND_BOUND, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 1'b1)};
        dir_rows = {dir_rows,
                    mk(KIND_TRANSFORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1'b0)};
        dir_rows = {dir_rows,
                    mk(KIND_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1)};
        dir_rows = {dir_rows, mk(KIND_TRANSFORM, 32'h0, 32'h0, 32'h0, 1'b0)};
        // small extent, x wider: saturating normalization
        dir_rows = {dir_rows, mk(KIND_BOUND, 32'd0, 32'd0, 32'd3, 1'b0)};
        dir_rows = {dir_rows, mk(KIND_BOUND, 32'd4, 32'd1, 32'hFFFF_FFFD, 1'b1)};
        dir_rows = {dir_rows, mk(KIND_TRANSFORM, 32'd2, 32'd0, 32'd7, 1'b0)};
        dir_rows = {dir_rows, mk(KIND_TRANSFORM, 32'd6, 32'hFFFF_FFFF, 32'd7, 1'b0)};
        dir_rows = {dir_rows,
                    mk(KIND_TRANSFORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'd7, 1'b0)};
        dir_rows = {dir_rows,
                    mk(KIND_TRANSFORM, 32'h7FFF_FFFF, 32'h8000_0000, 32'd7, 1'b1)};
        foreach (dir_rows[i]) send_point(dir_rows[i]);
        drain_results();

        // open pass interrupted by transforms, bounds must read as missing
        send_point(mk(KIND_BOUND, 32'd10, 32'd20, 32'd30, 1'b0));
        send_point(mk(KIND_TRANSFORM, 32'd11, 32'd21, 32'd31, 1'b0));
        send_point(mk(KIND_BOUND, 32'hFFFF_FFF0, 32'd40, 32'd1, 1'b1));
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            write_negate(ph[0] ? 1'b0 : 1'b1);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 48; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 48; end
                default: begin send_idle_pct = 13; recv_idle_pct = 13; end
            endcase
            for (int n = 0; n < 50; ) begin
                mode = $urandom_range(3, 0);
                pass_len = $urandom_range(6, 1);
                if ($urandom_range(9, 0) == 0) begin
                    // noise: stray transforms, some with last set
                    send_point(mk(KIND_TRANSFORM, rand_coord(mode), rand_coord(mode),
                                  rand_coord(mode), 1'($urandom_range(1, 0))));
                    n++;
                end else begin
                    for (int j = 0; j < pass_len; j++)
                        send_point(mk(KIND_BOUND, rand_coord(mode), rand_coord(mode),
                                      rand_coord(mode), j == pass_len - 1));
                    n += pass_len;
                    for (int j = $urandom_range(6, 1); j > 0; j--) begin
                        send_point(mk(KIND_TRANSFORM,
                                      $urandom_range(1, 0) ? rand_coord(mode) : $urandom(),
                                      rand_coord(mode), $urandom(),
                                      1'($urandom_range(1, 0))));
                        n++;
                    end
                end
            end
            send_idle_pct = 0;
            recv_idle_pct = 0;
            drain_results();
        end

        if (pending_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("covered %0d results (%0d bounds summaries) over 8 phases", results_seen,
                 summaries_seen);
        $display("depth negation toggled both ways, idle mixes on both channels");
        if (errors == 0) begin
            $display("bounding_box_normalizer_unit verification clean");
        end else begin
            $display("bounding_box_normalizer_unit verification failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
sv/bbn_pkg.sv
sv/bbn_front.sv
sv/bbn_queue.sv
sv/bbn_back.sv
sv/bounding_box_normalizer_unit.sv
tb/sv/tb_top.sv
